// File: rtl/bencode_pkg.sv
package bencode_pkg;

	localparam int LEN_BITS_DEF   = 32;
	localparam int DEPTH_BITS_DEF = 8;

	localparam logic [7:0] CH_DICT  = 8'h64;
	localparam logic [7:0] CH_LIST  = 8'h6C;
	localparam logic [7:0] CH_INT   = 8'h69;
	localparam logic [7:0] CH_END   = 8'h65;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] TOK_DICT  = 3'd0;
	localparam logic [2:0] TOK_LIST  = 3'd1;
	localparam logic [2:0] TOK_INT   = 3'd2;
	localparam logic [2:0] TOK_BYTE  = 3'd3;
	localparam logic [2:0] TOK_EMPTY = 3'd4;
	localparam logic [2:0] TOK_END   = 3'd5;
	localparam logic [2:0] TOK_PERR  = 3'd6;
	localparam logic [2:0] TOK_RERR  = 3'd7;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_LEN,
		MODE_DATA
	} mode_t;

	typedef struct packed {
		logic               emit;
		logic [2:0]         token_kind;
		logic signed [63:0] int_value;
		logic [7:0]         data_byte;
		logic               string_last;
		logic [31:0]        string_length;
		logic [7:0]         nest_depth;
		logic               value_complete;
	} tok_t;

endpackage

// File: rtl/bencode_in_if.sv
interface bencode_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       end_of_input;

	modport source (output valid, output byte_value, output end_of_input, input ready);
	modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

// File: rtl/bencode_out_if.sv
interface bencode_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         token_kind;
	logic signed [63:0] int_value;
	logic [7:0]         data_byte;
	logic               string_last;
	logic [31:0]        string_length;
	logic [7:0]         nest_depth;
	logic               value_complete;

	modport source (
		output valid, output token_kind, output int_value, output data_byte,
		output string_last, output string_length, output nest_depth,
		output value_complete, input ready
	);
	modport sink (
		input valid, input token_kind, input int_value, input data_byte,
		input string_last, input string_length, input nest_depth,
		input value_complete, output ready
	);
endinterface

// File: rtl/bencode_step.sv
module bencode_step #(
	parameter int LEN_BITS   = bencode_pkg::LEN_BITS_DEF,
	parameter int DEPTH_BITS = bencode_pkg::DEPTH_BITS_DEF
) (
	input  logic [7:0]            byte_value,
	input  logic                  end_of_input,
	input  bencode_pkg::mode_t    mode_q,
	input  logic [63:0]           acc_q,
	input  logic                  neg_q,
	input  logic [LEN_BITS-1:0]   rem_q,
	input  logic [LEN_BITS-1:0]   decl_q,
	input  logic [DEPTH_BITS-1:0] depth_q,
	output bencode_pkg::mode_t    mode_d,
	output logic [63:0]           acc_d,
	output logic                  neg_d,
	output logic [LEN_BITS-1:0]   rem_d,
	output logic [LEN_BITS-1:0]   decl_d,
	output logic [DEPTH_BITS-1:0] depth_d,
	output bencode_pkg::tok_t     tok
);
	import bencode_pkg::*;

	logic        is_digit, is_d, is_l, is_e, is_i, is_minus, is_colon;
	logic        depth_full, depth_zero, len_big, acc_zero, rem_one;
	logic        perr, rerr;
	logic [63:0] acc_next_digit, digit_val;
	logic [63:0] decl_wide;
	logic [15:0] depth_wide;

	assign is_digit   = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
	assign is_d       = byte_value == CH_DICT;
	assign is_l       = byte_value == CH_LIST;
	assign is_e       = byte_value == CH_END;
	assign is_i       = byte_value == CH_INT;
	assign is_minus   = byte_value == CH_MINUS;
	assign is_colon   = byte_value == CH_COLON;
	assign depth_full = &depth_q;
	assign depth_zero = depth_q == '0;
	assign len_big    = (acc_q >> LEN_BITS) != 64'd0;
	assign acc_zero   = acc_q == 64'd0;
	assign rem_one    = rem_q == LEN_BITS'(1);
	assign digit_val  = {60'd0, byte_value[3:0]};
	// x10 as shift-add, then the new digit
	assign acc_next_digit = (acc_q << 3) + (acc_q << 1) + digit_val;

	always_comb begin
		perr = 1'b0;
		rerr = 1'b0;
		if (end_of_input) begin
			rerr = mode_q != MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_IDLE: perr = ((is_d || is_l) && depth_full) || (is_e && depth_zero) ||
					!(is_d || is_l || is_e || is_i || is_digit);
				MODE_INT:  perr = !is_e && ((is_minus && neg_q) || (!is_minus && !is_digit));
				MODE_LEN:  perr = (is_colon && len_big) || (!is_colon && !is_digit);
				default:   perr = 1'b0;
			endcase
		end
	end

	// next state
	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		rem_d   = rem_q;
		decl_d  = decl_q;
		depth_d = depth_q;
		if (perr || rerr) begin
			mode_d  = MODE_IDLE;
			acc_d   = '0;
			neg_d   = 1'b0;
			rem_d   = '0;
			decl_d  = '0;
			depth_d = '0;
		end else if (!end_of_input) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (is_d || is_l) begin
						depth_d = depth_q + DEPTH_BITS'(1);
					end else if (is_e) begin
						depth_d = depth_q - DEPTH_BITS'(1);
					end else if (is_i) begin
						acc_d  = '0;
						neg_d  = 1'b0;
						mode_d = MODE_INT;
					end else begin
						acc_d  = digit_val;
						mode_d = MODE_LEN;
					end
				end
				MODE_INT: begin
					if (is_e) begin
						mode_d = MODE_IDLE;
						acc_d  = '0;
						neg_d  = 1'b0;
					end else if (is_minus) begin
						neg_d = 1'b1;
					end else begin
						acc_d = acc_next_digit;
					end
				end
				MODE_LEN: begin
					if (is_colon) begin
						decl_d = acc_q[LEN_BITS-1:0];
						rem_d  = acc_q[LEN_BITS-1:0];
						acc_d  = '0;
						mode_d = acc_zero ? MODE_IDLE : MODE_DATA;
					end else begin
						acc_d = acc_next_digit;
					end
				end
				MODE_DATA: begin
					rem_d = rem_q - LEN_BITS'(1);
					if (rem_one) begin
						mode_d = MODE_IDLE;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	assign decl_wide  = 64'(decl_q);
	assign depth_wide = 16'(depth_d);

	// token
	always_comb begin
		tok                = '0;
		tok.nest_depth     = depth_wide[7:0];
		if (perr) begin
			tok.emit       = 1'b1;
			tok.token_kind = TOK_PERR;
		end else if (rerr) begin
			tok.emit       = 1'b1;
			tok.token_kind = TOK_RERR;
		end else if (!end_of_input) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (is_d || is_l) begin
						tok.emit       = 1'b1;
						tok.token_kind = is_d ? TOK_DICT : TOK_LIST;
					end else if (is_e) begin
						tok.emit           = 1'b1;
						tok.token_kind     = TOK_END;
						tok.value_complete = depth_d == '0;
					end
				end
				MODE_INT: begin
					if (is_e) begin
						tok.emit           = 1'b1;
						tok.token_kind     = TOK_INT;
						tok.int_value      = neg_q ? -acc_q : acc_q;
						tok.value_complete = depth_zero;
					end
				end
				MODE_LEN: begin
					if (is_colon && acc_zero) begin
						tok.emit           = 1'b1;
						tok.token_kind     = TOK_EMPTY;
						tok.value_complete = depth_zero;
					end
				end
				MODE_DATA: begin
					tok.emit           = 1'b1;
					tok.token_kind     = TOK_BYTE;
					tok.data_byte      = byte_value;
					tok.string_last    = rem_one;
					tok.string_length  = decl_wide[31:0];
					tok.value_complete = rem_one && depth_zero;
				end
				default: tok.emit = 1'b0;
			endcase
		end
	end

endmodule

// File: rtl/bencode_token_stream_parser.sv
// A token appears on the output in the cycle after its byte is transferred.
// Throughput: one byte per cycle while no token is held by tokens.ready low; the output
// register frees as it is taken, so input and output may both move every cycle. Cycle
// time is set by the 64-bit x10 add. Reset (arst_n low, asynchronous): parser idle,
// accumulator, length and depth cleared, no token pending.
module bencode_token_stream_parser #(
	parameter int LEN_BITS   = bencode_pkg::LEN_BITS_DEF,
	parameter int DEPTH_BITS = bencode_pkg::DEPTH_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	bencode_in_if.sink   stream,
	bencode_out_if.source tokens
);
	import bencode_pkg::*;

	mode_t                 mode_q, mode_d;
	logic [63:0]           acc_q, acc_d;
	logic                  neg_q, neg_d;
	logic [LEN_BITS-1:0]   rem_q, rem_d;
	logic [LEN_BITS-1:0]   decl_q, decl_d;
	logic [DEPTH_BITS-1:0] depth_q, depth_d;
	tok_t                  tok;
	tok_t                  token_q;
	logic                  out_valid_q;
	logic                  accept;

	bencode_step #(
		.LEN_BITS   (LEN_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_step (
		.byte_value   (stream.byte_value),
		.end_of_input (stream.end_of_input),
		.mode_q       (mode_q),
		.acc_q        (acc_q),
		.neg_q        (neg_q),
		.rem_q        (rem_q),
		.decl_q       (decl_q),
		.depth_q      (depth_q),
		.mode_d       (mode_d),
		.acc_d        (acc_d),
		.neg_d        (neg_d),
		.rem_d        (rem_d),
		.decl_d       (decl_d),
		.depth_d      (depth_d),
		.tok          (tok)
	);

	assign stream.ready = !out_valid_q || tokens.ready;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			decl_q  <= '0;
			depth_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			rem_q   <= rem_d;
			decl_q  <= decl_d;
			depth_q <= depth_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= tok.emit;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && tok.emit) begin
			token_q <= tok;
		end
	end

	assign tokens.valid          = out_valid_q;
	assign tokens.token_kind     = token_q.token_kind;
	assign tokens.int_value      = token_q.int_value;
	assign tokens.data_byte      = token_q.data_byte;
	assign tokens.string_last    = token_q.string_last;
	assign tokens.string_length  = token_q.string_length;
	assign tokens.nest_depth     = token_q.nest_depth;
	assign tokens.value_complete = token_q.value_complete;

`ifndef SYNTH
	a_data_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DATA |-> rem_q != '0)
		else $error("payload mode with no bytes remaining");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tok.emit && (tok.token_kind == TOK_PERR || tok.token_kind == TOK_RERR)
		|=> mode_q == MODE_IDLE && depth_q == '0 && acc_q == '0)
		else $error("state not cleared after error");

	a_complete_at_top: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tok.emit && tok.value_complete |=> depth_q == '0)
		else $error("value complete flagged inside a container");
`endif

endmodule

// File: test/bencode_token_stream_parser_checker.sv
`timescale 1ns / 1ps

module bencode_token_stream_parser_checker (
	input  logic   clk,
	input  logic   arst_n,
	bencode_in_if  stream,
	bencode_out_if tokens,
	output int     fail_count,
	output int     pending_tokens
);
	import bencode_pkg::*;

	mode_t       mode;
	logic [63:0] acc;
	logic        neg;
	logic [31:0] remaining;
	logic [31:0] declared;
	logic [7:0]  depth;
	tok_t        expected_tokens[$];
	int          mismatches;
	int          queued;

	assign fail_count     = mismatches;
	assign pending_tokens = queued;

	initial begin
		mismatches = 0;
		queued     = 0;
	end

	function automatic void clear_state();
		mode      = MODE_IDLE;
		acc       = '0;
		neg       = 1'b0;
		remaining = '0;
		declared  = '0;
		depth     = '0;
	endfunction

	function automatic tok_t token(logic [2:0] kind, logic [63:0] ival, logic [7:0] data,
			logic last, logic [31:0] slen, logic done);
		tok_t t;
		t                = '0;
		t.emit           = 1'b1;
		t.token_kind     = kind;
		t.int_value      = ival;
		t.data_byte      = data;
		t.string_last    = last;
		t.string_length  = slen;
		t.nest_depth     = depth;
		t.value_complete = done;
		return t;
	endfunction

	function automatic tok_t fault(logic [2:0] kind);
		clear_state();
		return token(kind, '0, '0, 1'b0, '0, 1'b0);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic tok_t tokenize(logic [7:0] c, logic eoi);
		tok_t        t;
		logic [63:0] v;
		t = '0;
		if (eoi) begin
			if (mode != MODE_IDLE)
				t = fault(TOK_RERR);
			return t;
		end
		case (mode)
			MODE_IDLE: begin
				if (c == CH_DICT || c == CH_LIST) begin
					if (depth == 8'hFF) begin
						t = fault(TOK_PERR);
					end else begin
						depth = depth + 8'd1;
						t = token(c == CH_DICT ? TOK_DICT : TOK_LIST, '0, '0, 1'b0, '0, 1'b0);
					end
				end else if (c == CH_END) begin
					if (depth == 8'd0) begin
						t = fault(TOK_PERR);
					end else begin
						depth = depth - 8'd1;
						t = token(TOK_END, '0, '0, 1'b0, '0, depth == 8'd0);
					end
				end else if (c == CH_INT) begin
					acc  = '0;
					neg  = 1'b0;
					mode = MODE_INT;
				end else if (is_digit(c)) begin
					acc  = 64'(c - CH_ZERO);
					mode = MODE_LEN;
				end else begin
					t = fault(TOK_PERR);
				end
			end
			MODE_INT: begin
				if (c == CH_END) begin
					v    = neg ? -acc : acc;
					mode = MODE_IDLE;
					acc  = '0;
					neg  = 1'b0;
					t = token(TOK_INT, v, '0, 1'b0, '0, depth == 8'd0);
				end else if (c == CH_MINUS) begin
					if (neg)
						t = fault(TOK_PERR);
					else
						neg = 1'b1;
				end else if (!is_digit(c)) begin
					t = fault(TOK_PERR);
				end else begin
					acc = acc * 64'd10 + 64'(c - CH_ZERO);
				end
			end
			MODE_LEN: begin
				if (c == CH_COLON) begin
					if (acc > 64'h0000_0000_FFFF_FFFF) begin
						t = fault(TOK_PERR);
					end else begin
						declared  = acc[31:0];
						remaining = acc[31:0];
						acc       = '0;
						if (declared == 32'd0) begin
							mode = MODE_IDLE;
							t = token(TOK_EMPTY, '0, '0, 1'b0, '0, depth == 8'd0);
						end else begin
							mode = MODE_DATA;
						end
					end
				end else if (!is_digit(c)) begin
					t = fault(TOK_PERR);
				end else begin
					acc = acc * 64'd10 + 64'(c - CH_ZERO);
				end
			end
			default: begin
				remaining = remaining - 32'd1;
				if (remaining == 32'd0)
					mode = MODE_IDLE;
				t = token(TOK_BYTE, '0, c, remaining == 32'd0, declared,
					remaining == 32'd0 && depth == 8'd0);
			end
		endcase
		return t;
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tok_t exp;
		tok_t t;
		if (!arst_n) begin
			clear_state();
			expected_tokens.delete();
			queued = 0;
		end else begin
			if (tokens.valid && tokens.ready) begin
				if (expected_tokens.size() == 0) begin
					$error("token_kind: expected none, got %0h", tokens.token_kind);
					mismatches++;
				end else begin
					exp = expected_tokens.pop_front();
					check_field("token_kind", 64'(exp.token_kind), 64'(tokens.token_kind));
					check_field("int_value", exp.int_value, tokens.int_value);
					check_field("data_byte", 64'(exp.data_byte), 64'(tokens.data_byte));
					check_field("string_last", 64'(exp.string_last), 64'(tokens.string_last));
					check_field("string_length", 64'(exp.string_length),
						64'(tokens.string_length));
					check_field("nest_depth", 64'(exp.nest_depth), 64'(tokens.nest_depth));
					check_field("value_complete", 64'(exp.value_complete),
						64'(tokens.value_complete));
				end
			end
			if (stream.valid && stream.ready) begin
				t = tokenize(stream.byte_value, stream.end_of_input);
				if (t.emit)
					expected_tokens.push_back(t);
			end
			queued = expected_tokens.size();
		end
	end

endmodule

// File: test/bencode_token_stream_parser_tb.sv
`timescale 1ns / 1ps

module bencode_token_stream_parser_tb;
	import bencode_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_tokens;

	logic [8:0] byte_queue[$];
	int         bytes_sent;
	bit         send_idle;
	bit         recv_idle;
	bit         long_hold;

	bencode_in_if  stream ();
	bencode_out_if tokens ();

	bencode_token_stream_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.tokens (tokens)
	);

	bencode_token_stream_parser_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.stream         (stream),
		.tokens         (tokens),
		.fail_count     (fail_count),
		.pending_tokens (pending_tokens)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stall per transfer, one long hold on request
	initial begin
		int stall;
		tokens.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				stall     = 300;
				long_hold = 1'b0;
			end else begin
				stall = recv_idle ? $urandom_range(0, 19) : 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				tokens.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tokens.ready <= 1'b1;
			do @(posedge clk); while (!tokens.valid);
		end
	end

	task automatic send_byte(logic [7:0] b, logic eoi);
		int gap;
		gap = send_idle ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			stream.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream.valid        <= 1'b1;
		stream.byte_value   <= b;
		stream.end_of_input <= eoi;
		do @(posedge clk); while (!stream.ready);
		bytes_sent++;
	endtask

	task automatic flush();
		logic [8:0] item;
		while (byte_queue.size() > 0) begin
			item = byte_queue.pop_front();
			send_byte(item[7:0], item[8]);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		stream.valid <= 1'b0;
		while (pending_tokens != 0) @(negedge clk);
	endtask

	task automatic put_char(logic [7:0] c);
		byte_queue.push_back({1'b0, c});
	endtask

	task automatic put_eoi();
		byte_queue.push_back({1'b1, 8'($urandom_range(0, 255))});
	endtask

	task automatic put_text(string s);
		foreach (s[i])
			put_char(s[i]);
	endtask

	task automatic put_int();
		int r;
		int n;
		r = $urandom_range(0, 19);
		n = (r == 0) ? $urandom_range(19, 25) : (r == 1) ? 0 : $urandom_range(1, 6);
		put_char(CH_INT);
		if ($urandom_range(0, 4) == 0)
			put_char(CH_MINUS);
		repeat (n) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
		put_char(CH_END);
	endtask

	task automatic put_string();
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2)) put_char(CH_ZERO);
		put_text($sformatf("%0d", len));
		put_char(CH_COLON);
		repeat (len) put_char(8'($urandom_range(0, 255)));
	endtask

	task automatic put_value();
		int open;
		int r;
		open = 0;
		repeat ($urandom_range(1, 8)) begin
			r = $urandom_range(0, 99);
			if (open > 0 && r < 25) begin
				put_char(CH_END);
				open--;
			end else if (r < 50 && open < 6) begin
				put_char($urandom_range(0, 1) ? CH_DICT : CH_LIST);
				open++;
			end else if (r < 75) begin
				put_int();
			end else begin
				put_string();
			end
		end
		repeat (open) put_char(CH_END);
	endtask

	initial begin
		int r;
		int idx;
		arst_n              = 1'b0;
		stream.valid        = 1'b0;
		stream.byte_value   = 8'h00;
		stream.end_of_input = 1'b0;
		bytes_sent          = 0;
		send_idle           = 1'b1;
		recv_idle           = 1'b1;
		long_hold           = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nested dict/list, negative int, empty and one-byte string, closing ends,
		// unknown byte, stray end, double minus, end of input mid-token and idle, bare ie
		put_text("dli-7e0:1:");
		put_char(8'hFF);
		put_text("ee");
		put_char(8'h00);
		put_char(CH_END);
		put_text("i--");
		put_char(CH_INT);
		put_eoi();
		put_eoi();
		put_text("ie");
		flush();
		drain();

		// length limits
		put_text("4294967296:");
		put_text("4294967295:");
		repeat (3) put_char(8'($urandom_range(0, 255)));
		put_eoi();
		flush();
		drain();

		// full nesting depth then overflow, with output held off
		send_idle = 1'b0;
		long_hold = 1'b1;
		repeat (256) put_char(CH_LIST);
		flush();
		drain();

		while (bytes_sent < 1350) begin
			send_idle = $urandom_range(0, 4) != 0;
			recv_idle = $urandom_range(0, 4) != 0;
			r = $urandom_range(0, 99);
			if (r < 82) begin
				put_value();
			end else if (r < 88) begin
				repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
			end else if (r < 95) begin
				put_value();
				idx = $urandom_range(0, byte_queue.size() - 1);
				while (byte_queue.size() > idx)
					void'(byte_queue.pop_back());
				put_eoi();
			end else begin
				put_value();
				idx = $urandom_range(0, byte_queue.size() - 1);
				byte_queue[idx] = {1'b0, 8'($urandom_range(0, 255))};
			end
			flush();
			if ($urandom_range(0, 29) == 0)
				drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
